// File: hw/rtl/cmklm_pkg.sv
// ----------------------------------------------------------------------------
// cmklm_pkg
// Shared types, constants and helpers for the caseless multi-keyword line
// matcher.
// ----------------------------------------------------------------------------
package cmklm_pkg;

  // Upper bounds of the design, fixed by the register map
  localparam int MAX_KEYWORDS  = 4;
  localparam int MAX_KEY_BYTES = 8;

  // Defaults for the top-level parameters
  localparam int DEFAULT_KEYWORDS  = MAX_KEYWORDS;
  localparam int DEFAULT_KEY_BYTES = MAX_KEY_BYTES;

  // Register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTHS      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 3'd5;

  localparam int KEY_W     = 64;
  localparam int LEN_FIELD = 4;
  localparam int LENGTHS_W = MAX_KEYWORDS * LEN_FIELD;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Characters of interest
  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_NL      = 8'h0A;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Per-keyword results of one window compare
  typedef struct packed {
    logic [MAX_KEYWORDS-1:0] hit;    // keyword ends at the newest byte
    logic [MAX_KEYWORDS-1:0] empty;  // keyword has zero effective length
  } cmklm_match_t;

  // ASCII A-Z to a-z, everything else unchanged
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= BYTE_UPPER_A && c <= BYTE_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/cmklm_matcher.sv
// ----------------------------------------------------------------------------
// cmklm_matcher
// Parallel compare of every keyword against the newest bytes of the window.
// ----------------------------------------------------------------------------
module cmklm_matcher import cmklm_pkg::*; #(
  parameter int KEYWORDS  = DEFAULT_KEYWORDS,
  parameter int KEY_BYTES = DEFAULT_KEY_BYTES,
  localparam int CW = $clog2(KEY_BYTES + 1),
  localparam int WW = 8 * KEY_BYTES
) (
  input  logic [KEYWORDS-1:0][KEY_W-1:0] keywords,
  input  logic [LENGTHS_W-1:0]           lengths,
  input  logic [WW-1:0]                  window,   // newest byte in bits 7..0
  input  logic [CW-1:0]                  count,    // bytes in window, saturated
  output cmklm_match_t                   result
);

  logic [KEYWORDS-1:0] hit_k;
  logic [KEYWORDS-1:0] empty_k;

  for (genvar k = 0; k < KEYWORDS; k++) begin : g_key
    logic hit;
    logic empty;

    // Effective length, then compare for every candidate length
    always_comb begin : key_eval
      logic [LEN_FIELD-1:0] len_field;
      logic [CW-1:0]        len_sat;
      logic [CW-1:0]        len_eff;
      logic [KEY_BYTES:0]   fit;
      logic                 all_eq;
      logic [7:0]           kb;
      logic [7:0]           wb;

      len_field = lengths[LEN_FIELD*k +: LEN_FIELD];
      len_sat   = (len_field > LEN_FIELD'(KEY_BYTES)) ? CW'(KEY_BYTES) : CW'(len_field);

      // A NUL or newline inside the keyword ends it early
      len_eff = len_sat;
      for (int j = KEY_BYTES - 1; j >= 0; j--) begin
        kb = keywords[k][8*j +: 8];
        if (CW'(j) < len_sat && (kb == BYTE_NUL || kb == BYTE_NL)) begin
          len_eff = CW'(j);
        end
      end

      // fit[l]: first l keyword bytes equal the last l window bytes
      fit[0] = 1'b0;
      for (int l = 1; l <= KEY_BYTES; l++) begin
        all_eq = (count >= CW'(l));
        for (int j = 0; j < l; j++) begin
          kb = fold_byte(keywords[k][8*j +: 8]);
          wb = window[8*(l-1-j) +: 8];
          if (kb != wb) begin
            all_eq = 1'b0;
          end
        end
        fit[l] = all_eq;
      end

      hit   = fit[len_eff];
      empty = (len_eff == '0);
    end

    assign hit_k[k]   = hit;
    assign empty_k[k] = empty;
  end

  assign result.hit   = MAX_KEYWORDS'(hit_k);
  assign result.empty = MAX_KEYWORDS'(empty_k);

endmodule

// File: hw/rtl/caseless_multi_keyword_line_matcher.sv
// ----------------------------------------------------------------------------
// caseless_multi_keyword_line_matcher
// Case-insensitive search for up to four keywords in a stream of text lines.
// ----------------------------------------------------------------------------
// Text enters one byte per word on the slave stream; tlast marks the word
// that closes a line (its byte is ignored) and tuser clears the kept found
// mask before that word is handled. Bytes are folded to lower case and
// shifted into a window that every enabled keyword is checked against; a NUL
// or newline byte stops the line's text until its end. One result word
// leaves per line end. The block takes one word per clock: a word is held in
// the input register, the compare and state update happen between it and the
// result register, which makes a result valid on the master stream as its line
// end leaves the input register. Only a line end that finds the result register
// still full and not being taken holds the input back. Keywords, lengths and
// enables are to be written over the configuration channel only while no line
// end is in flight; the user is bound to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module caseless_multi_keyword_line_matcher import cmklm_pkg::*; #(
  parameter int KEYWORDS  = DEFAULT_KEYWORDS,
  parameter int KEY_BYTES = DEFAULT_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,

  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  // Text in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tlast,   // line_end
  input  logic                   s_axis_tuser,   // clear_found

  // Line results out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] line_hit, [4:1] line_key_mask,
                                                 // [8:5] found_mask, [15:9] zero
);

  localparam int CW = $clog2(KEY_BYTES + 1);
  localparam int WW = 8 * KEY_BYTES;

  // Configuration registers
  logic [KEYWORDS-1:0][KEY_W-1:0] keyword;
  logic [LENGTHS_W-1:0]           key_lengths;
  logic [MAX_KEYWORDS-1:0]        key_enable;
  logic [MAX_KEYWORDS-1:0]        key_valid;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;
  logic       s1_clear;

  // Line state
  logic [WW-1:0]           window;
  logic [WW-1:0]           window_next;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    stopped;
  logic [MAX_KEYWORDS-1:0] line_hits;
  logic [MAX_KEYWORDS-1:0] found;

  // Result register
  logic [3:0] out_mask;
  logic [3:0] out_found;

  logic       out_free;
  logic       proc;
  logic       text_ok;
  logic [7:0] folded;
  logic [WW+7:0] shifted;
  logic [MAX_KEYWORDS-1:0] end_mask;
  logic [MAX_KEYWORDS-1:0] found_base;
  cmklm_match_t            match;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword     <= '0;
      key_lengths <= '0;
      key_enable  <= '0;
    end else if (cfg_valid) begin
      for (int k = 0; k < KEYWORDS; k++) begin
        if (cfg_index == CFG_KEYWORD_BASE + CFG_INDEX_W'(k)) begin
          keyword[k] <= cfg_data;
        end
      end
      if (cfg_index == CFG_LENGTHS) begin
        key_lengths <= cfg_data[LENGTHS_W-1:0];
      end
      if (cfg_index == CFG_ENABLE) begin
        key_enable <= cfg_data[MAX_KEYWORDS-1:0];
      end
    end
  end

  // Keywords past KEYWORDS never take part
  assign key_valid = MAX_KEYWORDS'({KEYWORDS{1'b1}});

  // Handshake: the input register drains unless a line end meets a blocked output
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = s1_valid && (!s1_end || out_free);
  assign s_axis_tready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_byte  <= s_axis_tdata;
      s1_end   <= s_axis_tlast;
      s1_clear <= s_axis_tuser;
    end
  end

  // Candidate window after this byte
  assign folded      = fold_byte(s1_byte);
  assign shifted     = {window, folded};
  assign window_next = shifted[WW-1:0];
  assign count_next  = (count == CW'(KEY_BYTES)) ? count : count + CW'(1);
  assign text_ok     = !stopped && s1_byte != BYTE_NUL && s1_byte != BYTE_NL;

  cmklm_matcher #(
    .KEYWORDS  (KEYWORDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_matcher (
    .keywords (keyword),
    .lengths  (key_lengths),
    .window   (window_next),
    .count    (count_next),
    .result   (match)
  );

  // Line-end mask: hits so far plus empty keywords on a non-empty line
  assign end_mask   = (line_hits | (match.empty & {MAX_KEYWORDS{count != '0}}))
                      & key_enable & key_valid;
  assign found_base = s1_clear ? '0 : found;

  // Line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      count     <= '0;
      stopped   <= 1'b0;
      line_hits <= '0;
      found     <= '0;
    end else if (proc) begin
      if (s1_end) begin
        window    <= '0;
        count     <= '0;
        stopped   <= 1'b0;
        line_hits <= '0;
        found     <= found_base | end_mask;
      end else begin
        found <= found_base;
        if (!stopped && !text_ok) begin
          stopped <= 1'b1;
        end
        if (text_ok) begin
          window    <= window_next;
          count     <= count_next;
          line_hits <= line_hits | (match.hit & key_enable & key_valid);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc && s1_end) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_end) begin
      out_mask  <= end_mask;
      out_found <= found_base | end_mask;
    end
  end

  assign m_axis_tdata = {7'b0, out_found, out_mask, out_mask != '0};

  // Checks
  a_found_covers_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_mask & ~out_found) == '0)
    else $error("line mask not contained in found mask");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    proc && s1_end |=> count == '0 && !stopped && line_hits == '0)
    else $error("line state not cleared after line end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(KEY_BYTES))
    else $error("byte count past window size");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && s1_end && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked line result");

endmodule
